[sv/shph_pkg.sv]
// ----------------------------------------------------------------------------
// shph_pkg: shared types and constants of the sweep bin peak hold unit
// Field widths, configuration register indexes, the front-to-back command
// flags and the sweep phase encoding.
// ----------------------------------------------------------------------------
package shph_pkg;

  // Fixed field widths.
  localparam int SMP_W     = 16;  // signed Q8.8 sample
  localparam int VAL_W     = 15;  // unsigned Q7.8 maximum
  localparam int IDX_W     = 10;  // reported bin index
  localparam int VL_W      = 11;  // vector_length register
  localparam int VCNT_W    = 16;  // settle and dwell vector counts
  localparam int CFG_W     = 16;  // configuration write data
  localparam int CFG_IDX_W = 2;   // configuration register index

  // Default number of bins held in the maxima store.
  localparam int MAX_BINS_DEF = 1024;

  // Depth of the command queue between front and back.
  localparam int QUEUE_DEPTH = 4;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VECTOR_LENGTH  = 2'd0,
    CFG_SETTLE_VECTORS = 2'd1,
    CFG_DWELL_VECTORS  = 2'd2
  } cfg_idx_e;

  // Sweep phase, one-hot.
  typedef enum logic [3:0] {
    PH_INIT        = 4'b0001,
    PH_SETTLE      = 4'b0010,
    PH_DWELL_FIRST = 4'b0100,
    PH_DWELL       = 4'b1000
  } phase_e;

  // Flags of one command handed from the front to the back.
  typedef struct packed {
    logic tune;    // raise tune_request with this request
    logic mem;     // update the maxima store at the command's bin
    logic first;   // first dwell vector: overwrite instead of compare
    logic report;  // last dwell vector: report the bin's final maximum
    logic done;    // last bin of the finished dwell
  } cmd_ctl_t;

  localparam int CTL_W = $bits(cmd_ctl_t);

endpackage

[sv/shph_sample_if.sv]
// ----------------------------------------------------------------------------
// shph_sample_if: input channel of spectrum bin samples
// Valid/ready handshake carrying one signed Q8.8 bin value per request.
// ----------------------------------------------------------------------------
interface shph_sample_if;
  import shph_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [SMP_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);

endinterface

[sv/shph_result_if.sv]
// ----------------------------------------------------------------------------
// shph_result_if: output channel of retune requests and final maxima
// Valid/ready handshake carrying one result request.
// ----------------------------------------------------------------------------
interface shph_result_if;
  import shph_pkg::*;

  logic             valid;
  logic             ready;
  logic             tune_request;
  logic             has_max;
  logic [IDX_W-1:0] bin_index;
  logic [VAL_W-1:0] peak_value;
  logic             scan_done;

  modport source (output valid, output tune_request, output has_max, output bin_index,
                  output peak_value, output scan_done, input ready);
  modport sink   (input valid, input tune_request, input has_max, input bin_index,
                  input peak_value, input scan_done, output ready);

endinterface

[sv/shph_ram.sv]
// ----------------------------------------------------------------------------
// shph_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle. A read of the address being
// written in the same cycle returns the old contents.
// ----------------------------------------------------------------------------
module shph_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Storage write.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read; the output holds while no read is enabled.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/shph_queue.sv]
// ----------------------------------------------------------------------------
// shph_queue: short command queue between front and back
// A register FIFO; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module shph_queue #(
  parameter int DATA_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] push_data_i,
  output logic              ready_o,
  input  logic              pop_i,
  output logic              valid_o,
  output logic [DATA_W-1:0] pop_data_o
);
  import shph_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [DATA_W-1:0] slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wptr_q, wptr_d;
  logic [PTR_W-1:0]  rptr_q, rptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              do_push, do_pop;

  assign ready_o    = (count_q != CNT_W'(QUEUE_DEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = slot_q[rptr_q];
  assign do_push    = push_i && ready_o;
  assign do_pop     = pop_i && valid_o;

  // Pointer and fill-count update with wrap at the queue depth.
  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (do_push) begin
      wptr_d = (wptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  // Slot storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= push_data_i;
    end
  end

endmodule

[sv/shph_front.sv]
// ----------------------------------------------------------------------------
// shph_front: sample intake and sweep sequencing
// Holds the configuration registers, tracks phase, vector countdown and bin
// position, and turns each accepted sample into a command for the back part.
// Settling samples that raise no retune produce no command.
// ----------------------------------------------------------------------------
module shph_front #(
  parameter int MAX_BINS = shph_pkg::MAX_BINS_DEF
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          cfg_we_i,
  input  logic [shph_pkg::CFG_IDX_W-1:0]                cfg_idx_i,
  input  logic [shph_pkg::CFG_W-1:0]                    cfg_data_i,
  shph_sample_if.sink                                   sample_i,
  input  logic                                          queue_ready_i,
  output logic                                          push_o,
  output shph_pkg::cmd_ctl_t                            ctl_o,
  output logic [((MAX_BINS > 1) ? $clog2(MAX_BINS) : 1)-1:0] addr_o,
  output logic [shph_pkg::VAL_W-1:0]                    value_o
);
  import shph_pkg::*;

  localparam int BIN_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int LEN_W = BIN_W + 1;

  logic [VL_W-1:0]   vector_length_q;
  logic [VCNT_W-1:0] settle_vectors_q;
  logic [VCNT_W-1:0] dwell_vectors_q;

  phase_e            phase_q, phase_d, ph;
  logic [VCNT_W-1:0] countdown_q, countdown_d, cnt;
  logic [BIN_W-1:0]  pos_q, pos_d;

  logic [VCNT_W-1:0] dwell_eff;
  logic [LEN_W-1:0]  len;
  logic              last;
  logic              accept;
  logic              need_push;
  cmd_ctl_t          ctl;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vector_length_q  <= VL_W'(1024);
      settle_vectors_q <= '0;
      dwell_vectors_q  <= VCNT_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_VECTOR_LENGTH:  vector_length_q  <= cfg_data_i[VL_W-1:0];
        CFG_SETTLE_VECTORS: settle_vectors_q <= cfg_data_i[VCNT_W-1:0];
        CFG_DWELL_VECTORS:  dwell_vectors_q  <= cfg_data_i[VCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective dwell count and clamped vector length.
  assign dwell_eff = (dwell_vectors_q == '0) ? VCNT_W'(1) : dwell_vectors_q;

  always_comb begin
    if (vector_length_q == '0) begin
      len = LEN_W'(1);
    end else if (32'(vector_length_q) > MAX_BINS) begin
      len = LEN_W'(MAX_BINS);
    end else begin
      len = LEN_W'(vector_length_q);
    end
  end

  assign accept          = sample_i.valid && sample_i.ready;
  assign sample_i.ready  = queue_ready_i;

  // Phase sequencing and command classification.
  always_comb begin
    ph          = phase_q;
    cnt         = countdown_q;
    ctl         = '0;
    need_push   = 1'b0;

    // The first sample after reset requests a retune and joins the new phase.
    if (phase_q == PH_INIT) begin
      ctl.tune = 1'b1;
      if (settle_vectors_q == '0) begin
        ph  = PH_DWELL_FIRST;
        cnt = dwell_eff;
      end else begin
        ph  = PH_SETTLE;
        cnt = settle_vectors_q;
      end
    end

    last        = ({1'b0, pos_q} + LEN_W'(1)) >= len;
    phase_d     = ph;
    countdown_d = cnt;
    pos_d       = last ? '0 : pos_q + 1'b1;

    case (ph)
      PH_SETTLE: begin
        need_push = ctl.tune;
        if (last) begin
          if (cnt <= VCNT_W'(1)) begin
            phase_d     = PH_DWELL_FIRST;
            countdown_d = dwell_eff;
          end else begin
            countdown_d = cnt - 1'b1;
          end
        end
      end
      PH_DWELL_FIRST, PH_DWELL: begin
        need_push  = 1'b1;
        ctl.mem    = 1'b1;
        ctl.first  = (ph == PH_DWELL_FIRST);
        ctl.report = (cnt <= VCNT_W'(1));
        ctl.done   = ctl.report && last;
        if (last) begin
          if (cnt <= VCNT_W'(1)) begin
            // Dwell finished: retune and start the next step.
            ctl.tune = 1'b1;
            if (settle_vectors_q == '0) begin
              phase_d     = PH_DWELL_FIRST;
              countdown_d = dwell_eff;
            end else begin
              phase_d     = PH_SETTLE;
              countdown_d = settle_vectors_q;
            end
          end else begin
            countdown_d = cnt - 1'b1;
            phase_d     = PH_DWELL;
          end
        end
      end
      default: begin
        phase_d     = phase_q;
        countdown_d = countdown_q;
        pos_d       = pos_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_INIT;
      countdown_q <= '0;
      pos_q       <= '0;
    end else if (accept) begin
      phase_q     <= phase_d;
      countdown_q <= countdown_d;
      pos_q       <= pos_d;
    end
  end

  // Command to the queue; negative samples are floored at zero.
  assign push_o  = accept && need_push;
  assign ctl_o   = ctl;
  assign addr_o  = pos_q;
  assign value_o = sample_i.sample[SMP_W-1] ? '0 : sample_i.sample[VAL_W-1:0];

endmodule

[sv/shph_back.sv]
// ----------------------------------------------------------------------------
// shph_back: per-bin maximum update and result output
// Pops commands, reads the maxima store, merges the new sample, writes the
// store back and drives the result channel from an output register. A write
// and a read of the same bin in one cycle are bypassed.
// ----------------------------------------------------------------------------
module shph_back #(
  parameter int MAX_BINS = shph_pkg::MAX_BINS_DEF
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          q_valid_i,
  output logic                                          q_pop_o,
  input  shph_pkg::cmd_ctl_t                            q_ctl_i,
  input  logic [((MAX_BINS > 1) ? $clog2(MAX_BINS) : 1)-1:0] q_addr_i,
  input  logic [shph_pkg::VAL_W-1:0]                    q_value_i,
  shph_result_if.source                                 result_o
);
  import shph_pkg::*;

  localparam int BIN_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;

  // Update stage.
  logic             b_valid_q;
  cmd_ctl_t         b_ctl_q;
  logic [BIN_W-1:0] b_addr_q;
  logic [VAL_W-1:0] b_value_q;
  logic             fwd_q;
  logic [VAL_W-1:0] fwd_data_q;

  // Output register.
  logic             out_valid_q, out_valid_d;
  logic             out_tune_q;
  logic             out_has_max_q;
  logic [IDX_W-1:0] out_index_q;
  logic [VAL_W-1:0] out_peak_q;
  logic             out_done_q;

  logic             b_adv;
  logic             pop;
  logic             we;
  logic [VAL_W-1:0] rdata;
  logic [VAL_W-1:0] old_max;
  logic [VAL_W-1:0] new_max;
  logic             has_result;
  logic [IDX_W+BIN_W-1:0] index_ext;

  // Stage advance and queue pop.
  assign b_adv   = b_valid_q && (!out_valid_q || result_o.ready);
  assign pop     = q_valid_i && (!b_valid_q || b_adv);
  assign q_pop_o = pop;
  assign we      = b_adv && b_ctl_q.mem;

  shph_ram #(
    .WIDTH (VAL_W),
    .DEPTH (MAX_BINS)
  ) u_maxima (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (b_addr_q),
    .wdata_i (new_max),
    .re_i    (pop),
    .raddr_i (q_addr_i),
    .rdata_o (rdata)
  );

  // Merge the stored maximum with the sample; the first dwell vector overwrites.
  assign old_max = fwd_q ? fwd_data_q : rdata;
  assign new_max = (!b_ctl_q.first && (old_max > b_value_q)) ? old_max : b_value_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (pop) begin
      b_valid_q <= 1'b1;
    end else if (b_adv) begin
      b_valid_q <= 1'b0;
    end
  end

  // Command payload and same-bin bypass captured at pop time.
  always_ff @(posedge clk_i) begin
    if (pop) begin
      b_ctl_q    <= q_ctl_i;
      b_addr_q   <= q_addr_i;
      b_value_q  <= q_value_i;
      fwd_q      <= we && (b_addr_q == q_addr_i);
      fwd_data_q <= new_max;
    end
  end

  // Output register.
  assign has_result = b_ctl_q.tune || b_ctl_q.report;
  assign index_ext  = {{IDX_W{1'b0}}, b_addr_q};

  always_comb begin
    out_valid_d = out_valid_q;
    if (b_adv && has_result) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_adv && has_result) begin
      out_tune_q    <= b_ctl_q.tune;
      out_has_max_q <= b_ctl_q.report;
      out_index_q   <= b_ctl_q.report ? index_ext[IDX_W-1:0] : '0;
      out_peak_q    <= b_ctl_q.report ? new_max : '0;
      out_done_q    <= b_ctl_q.done;
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.tune_request = out_tune_q;
  assign result_o.has_max      = out_has_max_q;
  assign result_o.bin_index    = out_index_q;
  assign result_o.peak_value   = out_peak_q;
  assign result_o.scan_done    = out_done_q;

endmodule

[sv/sweep_bin_peak_hold_unit.sv]
// ----------------------------------------------------------------------------
// sweep_bin_peak_hold_unit: per-bin peak hold for a stepped spectrum sweep
// Requests a retune, skips settling vectors, then holds per-bin maxima over
// the dwell and reports them during the last dwell vector.
//
//   Channel    Dir  Handshake     Payload
//   sample_i   in   valid/ready   sample
//   result_o   out  valid/ready   tune_request, has_max, bin_index,
//                                 peak_value, scan_done
//   cfg        in   cfg_we_i      cfg_idx_i, cfg_data_i
//
// One sample is taken every cycle while the command queue is not full; a result
// passes from its accepted sample through the queue, the store read-modify-write
// stage and the output register.
// Reset clears the control state; the maxima store needs no clearing pass.
// A stalled output fills the command queue; sample_i.ready drops only when
// the queue is full.
// ----------------------------------------------------------------------------
module sweep_bin_peak_hold_unit #(
  parameter int MAX_BINS = shph_pkg::MAX_BINS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [shph_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [shph_pkg::CFG_W-1:0]     cfg_data_i,
  shph_sample_if.sink                    sample_i,
  shph_result_if.source                  result_o
);
  import shph_pkg::*;

  localparam int BIN_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int Q_W   = CTL_W + BIN_W + VAL_W;

  logic             push;
  cmd_ctl_t         f_ctl;
  logic [BIN_W-1:0] f_addr;
  logic [VAL_W-1:0] f_value;
  logic             q_ready;
  logic             q_valid;
  logic             q_pop;
  logic [Q_W-1:0]   q_data;
  cmd_ctl_t         q_ctl;
  logic [BIN_W-1:0] q_addr;
  logic [VAL_W-1:0] q_value;

  // Front: intake and sequencing.
  shph_front #(
    .MAX_BINS (MAX_BINS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .sample_i      (sample_i),
    .queue_ready_i (q_ready),
    .push_o        (push),
    .ctl_o         (f_ctl),
    .addr_o        (f_addr),
    .value_o       (f_value)
  );

  // Command queue.
  shph_queue #(
    .DATA_W (Q_W)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i ({f_ctl, f_addr, f_value}),
    .ready_o     (q_ready),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_data)
  );

  assign q_ctl   = q_data[Q_W-1 -: CTL_W];
  assign q_addr  = q_data[VAL_W +: BIN_W];
  assign q_value = q_data[VAL_W-1:0];

  // Back: maxima update and result output.
  shph_back #(
    .MAX_BINS (MAX_BINS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_pop_o   (q_pop),
    .q_ctl_i   (q_ctl),
    .q_addr_i  (q_addr),
    .q_value_i (q_value),
    .result_o  (result_o)
  );

endmodule

[tb/sweep_peak_monitor.sv]
// ----------------------------------------------------------------------------
// sweep_peak_monitor: prediction and checking for the sweep bin peak hold unit
// Watches the configuration port and both channels. Every accepted sample
// request runs through a cycle-free model of the sweep, and every result it
// causes is queued. Each accepted result request is compared field by field
// with the oldest queued one. The module also tells the stimulus how many
// results are still awaited and how long a vector may safely be made now.
// ----------------------------------------------------------------------------
module sweep_peak_monitor #(
  parameter int MAX_BINS = shph_pkg::MAX_BINS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [shph_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [shph_pkg::CFG_W-1:0]     cfg_data_i,
  shph_sample_if                         sample_i,
  shph_result_if                         result_i,
  output int                             mismatch_count_o,
  output int                             awaited_count_o,
  output int                             length_cap_o
);
  import shph_pkg::*;

  // One result request as the block should present it.
  typedef struct packed {
    logic             tune;
    logic             has_max;
    logic [IDX_W-1:0] bin;
    logic [VAL_W-1:0] peak;
    logic             done;
  } peak_report_t;

  // Configuration copy.
  logic [VL_W-1:0]   vec_len_cfg;
  logic [VCNT_W-1:0] settle_cfg;
  logic [VCNT_W-1:0] dwell_cfg;

  // Sweep state.
  phase_e            phase;
  int                vectors_left;
  int                bin_pos;
  int                written_hi;
  logic [VAL_W-1:0]  bin_peaks [MAX_BINS];

  peak_report_t      awaited_reports [$];
  int                awaited_n;
  int                mismatches = 0;

  assign mismatch_count_o = mismatches;
  assign awaited_count_o  = awaited_n;
  // Later dwell vectors read the store, so a longer vector is only safe up
  // to the bins that have been written so far.
  assign length_cap_o     = (phase == PH_DWELL) ? written_hi : MAX_BINS;

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  function automatic void enter_dwell();
    phase        = PH_DWELL_FIRST;
    vectors_left = (dwell_cfg == '0) ? 1 : int'(dwell_cfg);
  endfunction

  function automatic void enter_settle();
    if (settle_cfg == '0) begin
      enter_dwell();
    end else begin
      phase        = PH_SETTLE;
      vectors_left = int'(settle_cfg);
    end
  endfunction

  // Advance the sweep by one bin sample and queue the result it causes.
  task automatic hold_bin_peak(input logic [SMP_W-1:0] smp);
    logic [VAL_W-1:0] val;
    logic [VAL_W-1:0] peak;
    int               len;
    logic             last;
    peak_report_t     rep;
    val  = smp[SMP_W-1] ? '0 : smp[VAL_W-1:0];
    len  = (vec_len_cfg == '0) ? 1 : ((vec_len_cfg > MAX_BINS) ? MAX_BINS : int'(vec_len_cfg));
    rep  = '0;
    if (phase == PH_INIT) begin
      rep.tune = 1'b1;
      enter_settle();
    end
    last = (bin_pos + 1 >= len);
    if (phase == PH_SETTLE) begin
      if (last) begin
        bin_pos = 0;
        if (vectors_left <= 1) enter_dwell();
        else vectors_left--;
      end else begin
        bin_pos++;
      end
    end else begin
      // The first dwell vector overwrites, later ones keep the larger value.
      peak = val;
      if (phase == PH_DWELL && bin_peaks[bin_pos] > peak) peak = bin_peaks[bin_pos];
      bin_peaks[bin_pos] = peak;
      if (bin_pos + 1 > written_hi) written_hi = bin_pos + 1;
      if (vectors_left <= 1) begin
        rep.has_max = 1'b1;
        rep.bin     = bin_pos[IDX_W-1:0];
        rep.peak    = peak;
        rep.done    = last;
      end
      if (last) begin
        bin_pos = 0;
        if (vectors_left <= 1) begin
          rep.tune = 1'b1;
          enter_settle();
        end else begin
          vectors_left--;
          phase = PH_DWELL;
        end
      end else begin
        bin_pos++;
      end
    end
    if (rep.tune || rep.has_max) awaited_reports.push_back(rep);
  endtask

  // Compare one accepted result request with the oldest awaited one.
  task automatic check_report();
    peak_report_t want;
    if (awaited_reports.size() == 0) begin
      flag_mismatch("result with none awaited",
                    {result_i.tune_request, result_i.has_max, result_i.bin_index,
                     result_i.peak_value, result_i.scan_done}, '0);
    end else begin
      want = awaited_reports.pop_front();
      if (result_i.tune_request !== want.tune)
        flag_mismatch("tune_request", result_i.tune_request, want.tune);
      if (result_i.has_max !== want.has_max)
        flag_mismatch("has_max", result_i.has_max, want.has_max);
      if (result_i.bin_index !== want.bin)
        flag_mismatch("bin_index", result_i.bin_index, want.bin);
      if (result_i.peak_value !== want.peak)
        flag_mismatch("peak_value", result_i.peak_value, want.peak);
      if (result_i.scan_done !== want.done)
        flag_mismatch("scan_done", result_i.scan_done, want.done);
    end
  endtask

  // Registers, results and samples, in that order within one edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vec_len_cfg  = VL_W'(MAX_BINS_DEF);
      settle_cfg   = '0;
      dwell_cfg    = VCNT_W'(1);
      phase        = PH_INIT;
      vectors_left = 0;
      bin_pos      = 0;
      written_hi   = 0;
      foreach (bin_peaks[i]) bin_peaks[i] = '0;
      awaited_reports.delete();
      awaited_n    = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_VECTOR_LENGTH:  vec_len_cfg = cfg_data_i[VL_W-1:0];
          CFG_SETTLE_VECTORS: settle_cfg  = cfg_data_i[VCNT_W-1:0];
          CFG_DWELL_VECTORS:  dwell_cfg   = cfg_data_i[VCNT_W-1:0];
          default: ;
        endcase
      end
      if (result_i.valid === 1'b1 && result_i.ready === 1'b1) check_report();
      if (sample_i.valid === 1'b1 && sample_i.ready === 1'b1) hold_bin_peak(sample_i.sample);
      awaited_n = awaited_reports.size();
    end
  end

endmodule

[tb/sweep_bin_peak_hold_unit_tb.sv]
// ----------------------------------------------------------------------------
// sweep_bin_peak_hold_unit_tb: top of the sweep bin peak hold testbench
// Drives sample requests and configuration writes, stalls the result side at
// random and gives the verdict. A short directed part covers the sample
// extremes, zero dwell, out-of-range lengths and the first request after
// reset; random sweeps with changing settings follow, and a final part enters
// a settle phase with the largest settle and dwell counts. Checking is done by
// the monitor.
// ----------------------------------------------------------------------------
module sweep_bin_peak_hold_unit_tb;
  import shph_pkg::*;

  localparam int                   RANDOM_ITEMS   = 750;
  localparam int                   LONG_CNT_ITEMS = 8;
  localparam int                   DRAIN_CYCLES   = QUEUE_DEPTH + 8;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_data;

  int                   mismatch_count;
  int                   awaited_count;
  int                   length_cap;
  int                   scans_done = 0;
  int                   stall_left = 0;
  bit                   gaps_on = 1'b1;
  bit                   stalls_on = 1'b1;

  shph_sample_if smp_if ();
  shph_result_if res_if ();

  sweep_bin_peak_hold_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .sample_i   (smp_if),
    .result_o   (res_if)
  );

  sweep_peak_monitor peak_watch (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data),
    .sample_i         (smp_if),
    .result_i         (res_if),
    .mismatch_count_o (mismatch_count),
    .awaited_count_o  (awaited_count),
    .length_cap_o     (length_cap)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Mostly no pause, sometimes a short one, rarely a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int eff_length(input logic [CFG_W-1:0] v);
    if (v == '0) return 1;
    if (v > MAX_BINS_DEF) return MAX_BINS_DEF;
    return int'(v);
  endfunction

  // Mostly short vectors; now and then zero, oversize or large ones, but never
  // longer than the bins that later dwell vectors are allowed to read.
  function automatic logic [CFG_W-1:0] pick_length(input int cap);
    int               r;
    logic [CFG_W-1:0] v;
    r = $urandom_range(0, 99);
    if (r < 5) v = '0;
    else if (r < 8) v = 16'd2047;
    else if (r < 10) v = CFG_W'($urandom_range(1025, 2046));
    else if (r < 12) v = 16'd1024;
    else if (r < 17) v = CFG_W'($urandom_range(9, 1023));
    else v = CFG_W'($urandom_range(1, 8));
    if (eff_length(v) > cap) v = CFG_W'($urandom_range(1, cap));
    return v;
  endfunction

  function automatic logic [SMP_W-1:0] random_sample();
    case ($urandom_range(0, 15))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return SMP_W'($urandom_range(0, 255));
      default: return SMP_W'($urandom);
    endcase
  endfunction

  // One register write; the write enable is then dropped low before the task returns.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    @(posedge clk_i);
  endtask

  // One sample request, after an optional pause with valid low.
  task automatic send_sample(input logic [SMP_W-1:0] value);
    int gap;
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      smp_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    smp_if.valid  <= 1'b1;
    smp_if.sample <= value;
    do @(posedge clk_i); while (smp_if.ready !== 1'b1);
  endtask

  // Stop sending, let every awaited result arrive, then let the pipeline drain.
  task automatic wait_idle();
    smp_if.valid <= 1'b0;
    do @(posedge clk_i); while (awaited_count != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic sweep_until_done(input int scans);
    int target;
    target = scans_done + scans;
    while (scans_done < target) send_sample(random_sample());
  endtask

  // Result side: random stalls, with whole phases of none.
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left   <= stall_left - 1;
      res_if.ready <= 1'b0;
    end else if (stalls_on && $urandom_range(0, 99) < 20) begin
      stall_left   <= pick_gap();
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (res_if.valid === 1'b1 && res_if.ready === 1'b1 && res_if.scan_done === 1'b1)
      scans_done <= scans_done + 1;
  end

  // Stimulus and verdict.
  initial begin
    int               n;
    int               per_scan;
    int               random_items;
    int               settle_n;
    int               dwell_n;
    logic [CFG_W-1:0] cur_len;
    smp_if.valid  = 1'b0;
    smp_if.sample = '0;
    res_if.ready  = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = '0;
    cfg_data      = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zero dwell, the first request after reset, sample extremes.
    settle_n = $urandom_range(0, 1);
    write_reg(CFG_VECTOR_LENGTH, 16'd3);
    write_reg(CFG_SETTLE_VECTORS, CFG_W'(settle_n));
    write_reg(CFG_DWELL_VECTORS, 16'd0);
    send_sample(16'h8000);
    send_sample(16'h7FFF);
    send_sample(16'hFFFF);
    send_sample(16'h0001);
    send_sample(16'h0000);
    send_sample(16'h5555);
    wait_idle();

    // Directed: two dwell vectors, so the held maximum wins over negative samples.
    dwell_n = 2;
    write_reg(CFG_VECTOR_LENGTH, 16'd2);
    write_reg(CFG_DWELL_VECTORS, CFG_W'(dwell_n));
    send_sample(16'h0100);
    send_sample(16'h0080);
    send_sample(16'h00FF);
    send_sample(16'h0200);
    send_sample(16'h8001);
    send_sample(16'hAAAA);
    send_sample(16'hFFFF);
    send_sample(16'h7FFE);
    wait_idle();

    // Directed: a zero length acts as one bin; a write past the last register.
    cur_len = '0;
    write_reg(CFG_VECTOR_LENGTH, cur_len);
    write_reg(CFG_UNUSED_IDX, 16'hFFFF);
    send_sample(16'h1234);
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    send_sample(16'h0000);

    // Random sweeps, each phase started from an idle block, with settings changed at random.
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      wait_idle();
      gaps_on   = ($urandom_range(0, 3) != 0);
      stalls_on = ($urandom_range(0, 3) != 0);
      if (eff_length(cur_len) > 16 || $urandom_range(0, 1)) begin
        cur_len = pick_length(length_cap);
        write_reg(CFG_VECTOR_LENGTH, cur_len);
      end
      if ($urandom_range(0, 1)) begin
        settle_n = $urandom_range(0, 3);
        write_reg(CFG_SETTLE_VECTORS, CFG_W'(settle_n));
      end
      if ($urandom_range(0, 1)) begin
        dwell_n = $urandom_range(0, 4);
        write_reg(CFG_DWELL_VECTORS, CFG_W'(dwell_n));
      end
      if ($urandom_range(0, 9) == 0) write_reg(CFG_UNUSED_IDX, CFG_W'($urandom));

      // Mostly whole sweeps; sometimes a few stray bins that break alignment.
      per_scan = eff_length(cur_len) * (settle_n + ((dwell_n == 0) ? 1 : dwell_n));
      if ($urandom_range(0, 3) == 0) n = $urandom_range(1, 12);
      else if (per_scan > 48) n = $urandom_range(4, 40);
      else n = per_scan * $urandom_range(1, 2);
      repeat (n) begin
        send_sample(random_sample());
        random_items++;
      end
    end

    // Largest settle and dwell counts on one-bin vectors, without pauses. The
    // pending dwell ends with the next request, which retunes into a settle
    // phase of the largest length; a few settling bins follow.
    wait_idle();
    gaps_on = 1'b0;
    write_reg(CFG_VECTOR_LENGTH, 16'd1);
    write_reg(CFG_SETTLE_VECTORS, 16'd0);
    write_reg(CFG_DWELL_VECTORS, 16'd1);
    sweep_until_done(1);
    wait_idle();
    write_reg(CFG_SETTLE_VECTORS, 16'hFFFF);
    write_reg(CFG_DWELL_VECTORS, 16'hFFFF);
    repeat (LONG_CNT_ITEMS) send_sample(random_sample());
    wait_idle();

    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Run limit, several times the slowest correct run.
  initial begin
    #5000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

[filelist.f]
sv/shph_pkg.sv
sv/shph_sample_if.sv
sv/shph_result_if.sv
sv/shph_ram.sv
sv/shph_queue.sv
sv/shph_front.sv
sv/shph_back.sv
sv/sweep_bin_peak_hold_unit.sv
tb/sweep_peak_monitor.sv
tb/sweep_bin_peak_hold_unit_tb.sv
